>>> rtl/core/xsrng_pkg.sv
// ----------------------------------------------------------------------------
// xsrng_pkg
// request and result types and fixed constants of the xoshiro256** generator
// ----------------------------------------------------------------------------
package xsrng_pkg;

    // splitmix64 seed expansion constants
    localparam logic [63:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SM_MUL1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SM_MUL2  = 64'h94D0_49BB_1331_11EB;

    // request codes
    localparam logic ACT_RAW    = 1'b0;
    localparam logic ACT_RANGED = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] range_min;
        logic signed [31:0] range_max;
    } t_req;

    typedef struct packed {
        logic        [63:0] raw_word;
        logic signed [31:0] ranged_value;
    } t_rsp;

endpackage

>>> rtl/core/xoshiro256ss_ranged_rng.sv
// ----------------------------------------------------------------------------
// xoshiro256ss_ranged_rng
// xoshiro256** generator with splitmix64 seeding and a ranged-integer mode
// ----------------------------------------------------------------------------
// channel   direction  handshake                   payload
// request   in         i_in_valid / o_in_stall     i_in_req   (xsrng_pkg::t_req)
// result    out        o_out_valid / i_out_stall   o_out_rsp  (xsrng_pkg::t_rsp)
// seed      in         i_cfg_valid / o_cfg_ready   i_cfg_data (64 bit seed)
//
// raw request: ST_WORD scrambles the word, ST_DONE loads the result register, then idle
// ranged request: ST_WORD, then the bit-serial remainder in ST_DIV (one dividend bit a
//   cycle), ST_FIN adds min, and ST_DONE loads the result register
// empty range (max <= min): accept goes straight to ST_DONE, which loads min into the
//   result register; the state does not advance
// reset or seed write: seeding of 4 words, each one add step and two bit-serial
//   shift-add multiplies; requests stalled meanwhile and while a seed write is offered
// a finished result waits in the output register while the next request is worked on;
//   a stalled result holds the next one in the sequencer, so requests stall behind it
// ----------------------------------------------------------------------------
module xoshiro256ss_ranged_rng (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  xsrng_pkg::t_req i_in_req,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output xsrng_pkg::t_rsp o_out_rsp,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [63:0]     i_cfg_data
);
    import xsrng_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request
    localparam logic [2:0] ST_SADD = 3'd1;  // splitmix64 add and first mix
    localparam logic [2:0] ST_SMUL = 3'd2;  // bit-serial multiply by a mix constant
    localparam logic [2:0] ST_WORD = 3'd3;  // rotate and times nine
    localparam logic [2:0] ST_DIV  = 3'd4;  // restoring remainder, one bit a cycle
    localparam logic [2:0] ST_FIN  = 3'd5;  // add min to the remainder
    localparam logic [2:0] ST_DONE = 3'd6;  // result waits for the output register

    // control
    logic [2:0]  r_state;
    logic [5:0]  r_cnt;
    logic [1:0]  r_idx;
    logic        r_pass;
    logic [63:0] r_acc;
    logic        r_out_valid;

    // payload
    logic [63:0] r_gen [4];
    logic [63:0] r_mcand;
    logic [63:0] r_mplier;
    logic [63:0] r_prod;
    logic [63:0] r_word;
    logic [31:0] r_rem;
    logic [31:0] r_lo;
    logic [31:0] r_diff;
    logic        r_ranged;
    t_rsp        r_res;
    t_rsp        r_out;

    logic        in_acc;
    logic        cfg_acc;
    logic        out_free;
    logic        empty_rng;
    logic [63:0] s1x5;
    logic [63:0] w_rot;
    logic [63:0] word9;
    logic [63:0] n_acc;
    logic [63:0] mix0;
    logic [63:0] prod_sum;
    logic [63:0] mix1;
    logic [63:0] mix_fin;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic [31:0] n_rem;
    logic [63:0] n_gen0, n_gen1, n_gen2, n_gen3, gen3_x;

    // handshakes, a seed write wins over a request in the same cycle
    assign o_in_stall  = (r_state != ST_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE) || (r_state == ST_SADD) || (r_state == ST_SMUL);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    assign empty_rng = (i_in_req.range_max <= i_in_req.range_min);

    // scrambler: (s1 * 5) at accept, then rotl 7 and times nine
    assign s1x5  = r_gen[1] + {r_gen[1][61:0], 2'b00};
    assign w_rot = {r_word[56:0], r_word[63:57]};
    assign word9 = w_rot + {w_rot[60:0], 3'b000};

    // xoshiro256 state transition
    assign gen3_x = r_gen[3] ^ r_gen[1];
    assign n_gen2 = r_gen[2] ^ r_gen[0] ^ {r_gen[1][46:0], 17'd0};
    assign n_gen1 = r_gen[1] ^ r_gen[2] ^ r_gen[0];
    assign n_gen0 = r_gen[0] ^ gen3_x;
    assign n_gen3 = {gen3_x[18:0], gen3_x[63:19]};

    // splitmix64 datapath, multiplies are bit-serial shift-add
    assign n_acc    = r_acc + SM_GAMMA;
    assign mix0     = n_acc ^ (n_acc >> 30);
    assign prod_sum = r_prod + (r_mplier[0] ? r_mcand : 64'd0);
    assign mix1     = prod_sum ^ (prod_sum >> 27);
    assign mix_fin  = prod_sum ^ (prod_sum >> 31);

    // remainder step: shift in the next dividend bit, subtract span if it fits
    assign rem_sh  = {r_rem, r_word[63]};
    assign rem_sub = rem_sh - {1'b0, r_diff} - 33'd1;
    assign n_rem   = (rem_sh > {1'b0, r_diff}) ? rem_sub[31:0] : rem_sh[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SADD;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_pass      <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register drains independently of the sequencer
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_acc) begin
                // new seed restarts the expansion
                r_acc   <= i_cfg_data;
                r_idx   <= '0;
                r_state <= ST_SADD;
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (in_acc) begin
                            if (i_in_req.action == ACT_RANGED && empty_rng) begin
                                r_state <= ST_DONE;
                            end else begin
                                r_state <= ST_WORD;
                            end
                        end
                    end
                    ST_SADD: begin
                        r_acc   <= n_acc;
                        r_cnt   <= '0;
                        r_pass  <= 1'b0;
                        r_state <= ST_SMUL;
                    end
                    ST_SMUL: begin
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd63) begin
                            if (!r_pass) begin
                                r_pass <= 1'b1;
                            end else begin
                                r_idx   <= r_idx + 2'd1;
                                r_state <= (r_idx == 2'd3) ? ST_IDLE : ST_SADD;
                            end
                        end
                    end
                    ST_WORD: begin
                        r_cnt   <= '0;
                        r_state <= r_ranged ? ST_DIV : ST_DONE;
                    end
                    ST_DIV: begin
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd63) begin
                            r_state <= ST_FIN;
                        end
                    end
                    ST_FIN: begin
                        r_state <= ST_DONE;
                    end
                    ST_DONE: begin
                        if (out_free) begin
                            r_state <= ST_IDLE;
                        end
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out <= r_res;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_ranged <= i_in_req.action;
                    r_lo     <= i_in_req.range_min;
                    r_diff   <= i_in_req.range_max - i_in_req.range_min;
                    if (i_in_req.action == ACT_RANGED && empty_rng) begin
                        // empty range: min back, generator holds
                        r_res.raw_word     <= '0;
                        r_res.ranged_value <= i_in_req.range_min;
                    end else begin
                        r_word   <= s1x5;
                        r_gen[0] <= n_gen0;
                        r_gen[1] <= n_gen1;
                        r_gen[2] <= n_gen2;
                        r_gen[3] <= n_gen3;
                    end
                end
            end
            ST_SADD: begin
                r_mcand  <= mix0;
                r_mplier <= SM_MUL1;
                r_prod   <= '0;
            end
            ST_SMUL: begin
                if (r_cnt == 6'd63 && !r_pass) begin
                    // second multiply starts on the mixed first product
                    r_mcand  <= mix1;
                    r_mplier <= SM_MUL2;
                    r_prod   <= '0;
                end else begin
                    r_prod   <= prod_sum;
                    r_mcand  <= {r_mcand[62:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[63:1]};
                end
                if (r_cnt == 6'd63 && r_pass) begin
                    r_gen[r_idx] <= mix_fin;
                end
            end
            ST_WORD: begin
                r_word             <= word9;
                r_rem              <= '0;
                r_res.raw_word     <= word9;
                r_res.ranged_value <= '0;
            end
            ST_DIV: begin
                // rotate so the word is back in place after 64 steps
                r_word <= {r_word[62:0], r_word[63]};
                r_rem  <= n_rem;
            end
            ST_FIN: begin
                r_res.raw_word     <= r_word;
                r_res.ranged_value <= r_lo + r_rem;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/core/xsrng_checker.sv
// ----------------------------------------------------------------------------
// xsrng_checker
// port-level checks of the xoshiro256** generator, bound to the top level
// ----------------------------------------------------------------------------
module xsrng_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input xsrng_pkg::t_rsp o_out_rsp,
    input logic            i_cfg_valid,
    input logic            o_cfg_ready
);
    import xsrng_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_rsp))
        else $error("result changed while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    // seed write starts seeding, requests held off
    a_seed_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> o_in_stall)
        else $error("request channel open during seeding");

    // reset empties the output and begins seeding
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("bad state after reset");

endmodule

bind xoshiro256ss_ranged_rng xsrng_checker u_xsrng_checker (.*);

>>> sim/tb_xoshiro256ss_ranged_rng.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xoshiro256ss_ranged_rng
// self-checking bench for the xoshiro256** generator with ranged requests.
// a scoreboard class mirrors the splitmix64 seeding and the xoshiro256**
// state update and predicts each result; requests run through a directed
// set and then random phases under several seeds, with random idling on
// both channels and long result hold-offs
// ----------------------------------------------------------------------------

class xoshiro_scoreboard;

    logic [63:0]     gen_word [4];
    xsrng_pkg::t_rsp pending_rsp [$];
    int              errors;

    // splitmix64 expansion of a seed into the four state words
    function void reseed(logic [63:0] seed);
        logic [63:0] acc;
        logic [63:0] z;
        acc = seed;
        for (int i = 0; i < 4; i++) begin
            acc = acc + xsrng_pkg::SM_GAMMA;
            z   = acc;
            z   = (z ^ (z >> 30)) * xsrng_pkg::SM_MUL1;
            z   = (z ^ (z >> 27)) * xsrng_pkg::SM_MUL2;
            gen_word[i] = z ^ (z >> 31);
        end
    endfunction

    // one xoshiro256** step, returns the scrambled word
    function logic [63:0] draw_word();
        logic [63:0] m5;
        logic [63:0] scrambled;
        logic [63:0] shl;
        m5        = gen_word[1] * 64'd5;
        scrambled = {m5[56:0], m5[63:57]} * 64'd9;
        shl       = gen_word[1] << 17;
        gen_word[2] = gen_word[2] ^ gen_word[0];
        gen_word[3] = gen_word[3] ^ gen_word[1];
        gen_word[1] = gen_word[1] ^ gen_word[2];
        gen_word[0] = gen_word[0] ^ gen_word[3];
        gen_word[2] = gen_word[2] ^ shl;
        gen_word[3] = {gen_word[3][18:0], gen_word[3][63:19]};
        return scrambled;
    endfunction

    function void note_request(xsrng_pkg::t_req req);
        xsrng_pkg::t_rsp     rsp;
        logic signed [63:0]  lo;
        logic signed [63:0]  hi;
        logic [63:0]         span;
        logic [63:0]         rem;
        lo = req.range_min;
        hi = req.range_max;
        if (req.action == xsrng_pkg::ACT_RAW) begin
            rsp.raw_word     = draw_word();
            rsp.ranged_value = '0;
        end else if (req.range_max <= req.range_min) begin
            // empty range, generator holds still
            rsp.raw_word     = '0;
            rsp.ranged_value = req.range_min;
        end else begin
            span             = 64'(hi - lo) + 64'd1;
            rsp.raw_word     = draw_word();
            rem              = rsp.raw_word % span;
            rsp.ranged_value = req.range_min + rem[31:0];
        end
        pending_rsp.push_back(rsp);
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %h got %h", what, want, got);
    endfunction

    function void check_result(xsrng_pkg::t_rsp got);
        xsrng_pkg::t_rsp want;
        if (pending_rsp.size() == 0) begin
            report("unexpected result", '0, got.raw_word);
        end else begin
            want = pending_rsp.pop_front();
            if (got.raw_word !== want.raw_word)
                report("raw_word", want.raw_word, got.raw_word);
            if (got.ranged_value !== want.ranged_value)
                report("ranged_value", 64'(unsigned'(want.ranged_value)),
                       64'(unsigned'(got.ranged_value)));
        end
    endfunction

    function int pending();
        return pending_rsp.size();
    endfunction

endclass

module tb_xoshiro256ss_ranged_rng;

    // no acceptance on any channel for this long means a hang; the worst
    // honest gap is a reseed or a result hold-off on top of a ranged request
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEMS_PER_PH = 125;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_stall;
    xsrng_pkg::t_req i_in_req;
    logic            o_out_valid;
    logic            i_out_stall;
    xsrng_pkg::t_rsp o_out_rsp;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [63:0]     i_cfg_data;

    xoshiro_scoreboard sb = new();

    int rsp_count;
    int quiet_cycles;
    bit steady;

    xoshiro256ss_ranged_rng dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // monitors: accepted requests feed the predictor, accepted results are
    // checked, a seed write reseeds the predicted state
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_in_req);
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_rsp);
                rsp_count++;
            end
            if (i_cfg_valid && o_cfg_ready)
                sb.reseed(i_cfg_data);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side: random stall, none in the steady window, and two long
    // hold-offs so the block backs up and stalls its request input
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        int next_hold;
        hold_left   = 0;
        next_hold   = 100;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && next_hold <= 330 && rsp_count >= next_hold) begin
                hold_left = HOLD_CYCLES;
                next_hold = next_hold + 230;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !steady && ($urandom_range(99) < 32);
            end
        end
    end

    // ------------------------------------------------------------------------
    // request and seed drivers
    // ------------------------------------------------------------------------

    // offer one request, with random idle cycles ahead of it, and hold it
    // until accepted; valid stays high when the next request follows at once
    task automatic send_request(xsrng_pkg::t_req req);
        while (!steady && $urandom_range(99) < 32) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // only called with nothing in flight
    task automatic write_seed(logic [63:0] seed);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= seed;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // drop valid after a batch and wait for every result to come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic xsrng_pkg::t_req make_req(logic act, logic [31:0] lo,
                                                 logic [31:0] hi);
        xsrng_pkg::t_req req;
        req.action    = act;
        req.range_min = lo;
        req.range_max = hi;
        return req;
    endfunction

    // random request; the range fields stay random on raw requests too
    function automatic xsrng_pkg::t_req random_req();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom;
        hi = $urandom;
        case ($urandom_range(5))
            2: hi = lo + $urandom_range(1, 64);               // narrow span
            3: hi = ($urandom_range(1) != 0) ? lo : lo - 1;   // empty range
            4: begin                                          // near full span
                lo = 32'h8000_0000 + $urandom_range(3);
                hi = 32'h7FFF_FFFF - $urandom_range(3);
            end
            5: hi = lo + ((32'd1 << $urandom_range(31)) - 1);  // power of two span
            default: ;
        endcase
        return make_req(1'($urandom_range(1)), lo, hi);
    endfunction

    initial begin
        xsrng_pkg::t_req directed [$];
        logic [63:0]     seeds [4];

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        rsp_count   = 0;
        quiet_cycles = 0;
        steady      = 1'b0;

        // reset seeds the generator from zero
        sb.reseed(64'h0);

        seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        seeds[1] = 64'h0;
        seeds[2] = {$urandom, $urandom};
        seeds[3] = 64'h1;

        // extremes, both request kinds and the empty range forms
        directed.push_back(make_req(xsrng_pkg::ACT_RAW,    32'h0,         32'h0));
        directed.push_back(make_req(xsrng_pkg::ACT_RAW,    32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'h8000_0000, 32'h7FFF_FFFF));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'h0,         32'h0));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'h7FFF_FFFF, 32'h8000_0000));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'h8000_0000, 32'h8000_0000));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'd10,        32'd3));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'h0,         32'h1));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'hFFFF_FFFF, 32'h0));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'h8000_0000, 32'h8000_0001));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'h7FFF_FFFE, 32'h7FFF_FFFF));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'd5,         32'd100));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, -32'sd100,     -32'sd50));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'h8000_0000, 32'h0));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'h0,         32'h7FFF_FFFF));
        directed.push_back(make_req(xsrng_pkg::ACT_RAW,    32'h7FFF_FFFF, 32'h8000_0000));
        directed.push_back(make_req(xsrng_pkg::ACT_RANGED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the reset seed
        foreach (directed[i])
            send_request(directed[i]);
        drain();

        // random phases, one per seed; the second phase opens without idling
        for (int ph = 0; ph < 4; ph++) begin
            write_seed(seeds[ph]);
            for (int n = 0; n < ITEMS_PER_PH; n++) begin
                steady = (ph == 1) && (n < 80);
                send_request(random_req());
            end
            steady = 1'b0;
            drain();
        end

        // let any stray result surface
        repeat (100) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
